FILE: src/ist_pkg.sv
// package: widths, op and status codes, state type and chain control struct
package ist_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int INDEX_W  = 6;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_MEMBER = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              shift;
    logic              inject;
    logic [DATA_W-1:0] data;
  } chain_ctl_t;

endpackage

FILE: src/ist_in_if.sv
// interface: command channel carrying op, value and index
interface ist_in_if;
  import ist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;
  logic [INDEX_W-1:0]       index;

  modport source (output valid, op, value, index, input ready);
  modport sink   (input valid, op, value, index, output ready);
endinterface

FILE: src/ist_out_if.sv
// interface: result channel carrying found, read value, count, empty flag and status
interface ist_out_if;
  import ist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     found;
  logic signed [DATA_W-1:0] read_value;
  logic [CNT_W-1:0]         count;
  logic                     empty_res;
  logic [STAT_W-1:0]        status;

  modport source (output valid, found, read_value, count, empty_res, status, input ready);
  modport sink   (input valid, found, read_value, count, empty_res, status, output ready);
endinterface

FILE: src/ist_cell.sv
// one storage cell of the ring: loads its neighbor's entry on a shift
module ist_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [ist_pkg::DATA_W-1:0] d,
  output logic [ist_pkg::DATA_W-1:0] q
);
  import ist_pkg::*;

  logic [DATA_W-1:0] entry_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry_r <= d;
    end
  end

  assign q = entry_r;
endmodule

FILE: src/ist_chain.sv
// ring of storage cells; the tail takes the head entry or an injected value
module ist_chain (
  input  logic                       clk,
  input  ist_pkg::chain_ctl_t        ctl,
  output logic [ist_pkg::DATA_W-1:0] head
);
  import ist_pkg::*;

  logic [DATA_W-1:0] link [CAPACITY];
  logic [DATA_W-1:0] tail_d;

  assign tail_d = ctl.inject ? ctl.data : link[0];
  assign head   = link[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_tail
      ist_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .d     (tail_d),
        .q     (link[i])
      );
    end else begin : g_body
      ist_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .d     (link[i+1]),
        .q     (link[i])
      );
    end
  end
endmodule

FILE: src/integer_set_table_core.sv
// top level: unordered integer set held in a rotating ring of cells
//
//  channel | dir | transfer when            | payload
//  in_ch   | in  | in_ch.valid & ready      | op, value, index
//  out_ch  | out | out_ch.valid & ready     | found, read_value, count, empty_res, status
//
// insert, member, remove and in-range read rotate the ring once in the scan state;
// logical entry k sits in the head cell at step k
// a remove that finds its value takes a second full pass to write the last entry into the hole
// clear, unused codes, insert when full and out-of-range read go straight to the done state
// synchronous active-low reset clears control and the count; entries are not reset
// a finished result waits in the output register; the next command is taken while
// it waits, and the following result holds in the done state until the register frees
module integer_set_table_core (
  input  logic       clk,
  input  logic       rst_n,
  ist_in_if.sink     in_ch,
  ist_out_if.source  out_ch
);
  import ist_pkg::*;

  state_t state_r, state_nxt;

  // latched command
  logic [OP_W-1:0]    op_r;
  logic [DATA_W-1:0]  value_r;
  logic [INDEX_W-1:0] index_r;

  // store bookkeeping and scan results
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  step_r;
  logic [IDX_W-1:0]  pos_r;
  logic [DATA_W-1:0] last_r;
  logic [DATA_W-1:0] rd_r;
  logic              found_r;
  logic [STAT_W-1:0] status_r;

  // output register
  logic              out_valid_r;
  logic              out_found_r;
  logic [DATA_W-1:0] out_rd_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_empty_r;
  logic [STAT_W-1:0] out_status_r;

  logic [DATA_W-1:0] head;
  chain_ctl_t        ctl;

  logic in_xfer, out_free, full, idx_ok, need_pass;
  logic last_step, in_store, hit, found_nxt;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign idx_ok    = (CMP_W'(in_ch.index) < CMP_W'(count_r));
  assign last_step = (step_r == IDX_W'(CAPACITY - 1));
  assign in_store  = (CNT_W'(step_r) < count_r);
  assign hit       = in_store && (head == value_r);
  assign found_nxt = found_r || hit;

  always_comb begin
    unique case (in_ch.op)
      OP_INSERT: need_pass = !full;
      OP_MEMBER: need_pass = 1'b1;
      OP_REMOVE: need_pass = 1'b1;
      OP_READ:   need_pass = idx_ok;
      default:   need_pass = 1'b0;
    endcase
  end

  // ring chain
  ist_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = need_pass ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (last_step) begin
          state_nxt = (op_r == OP_REMOVE && found_nxt) ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: begin
        if (last_step) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs: handshake and ring control
  always_comb begin
    in_ch.ready = 1'b0;
    ctl.shift   = 1'b0;
    ctl.inject  = 1'b0;
    ctl.data    = value_r;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_SCAN: begin
        ctl.shift  = 1'b1;
        // insert drops the new value into the first free slot
        ctl.inject = (op_r == OP_INSERT) && (CNT_W'(step_r) == count_r);
      end
      ST_WRITE: begin
        ctl.shift  = 1'b1;
        // last entry fills the hole left by the removed one
        ctl.inject = (step_r == pos_r);
        ctl.data   = last_r;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command latch, scan tracking and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            op_r     <= in_ch.op;
            value_r  <= in_ch.value;
            index_r  <= in_ch.index;
            found_r  <= 1'b0;
            rd_r     <= '0;
            status_r <= STAT_OK;
            step_r   <= '0;
            if (in_ch.op == OP_CLEAR) begin
              count_r <= '0;
            end
            if (in_ch.op == OP_INSERT && full) begin
              status_r <= STAT_FULL;
            end
            if (in_ch.op == OP_READ && !idx_ok) begin
              status_r <= STAT_RANGE;
            end
          end
        end
        ST_SCAN: begin
          step_r <= last_step ? '0 : step_r + 1'b1;
          if (op_r == OP_MEMBER && hit) begin
            found_r <= 1'b1;
          end
          if (op_r == OP_REMOVE) begin
            if (hit && !found_r) begin
              found_r <= 1'b1;
              pos_r   <= step_r;
            end
            if (CNT_W'(step_r) == count_r - 1'b1) begin
              last_r <= head;
            end
          end
          if (op_r == OP_READ && CMP_W'(step_r) == CMP_W'(index_r)) begin
            rd_r <= head;
          end
          if (last_step && op_r == OP_INSERT) begin
            count_r <= count_r + 1'b1;
          end
        end
        ST_WRITE: begin
          step_r <= last_step ? '0 : step_r + 1'b1;
          if (last_step) begin
            count_r <= count_r - 1'b1;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && out_free) begin
        out_valid_r  <= 1'b1;
        out_found_r  <= found_r;
        out_rd_r     <= rd_r;
        out_count_r  <= count_r;
        out_empty_r  <= (count_r == '0);
        out_status_r <= status_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.empty_res  = out_empty_r;
  assign out_ch.status     = out_status_r;

  // count never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // the ring is back in alignment whenever no pass runs
  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> step_r == '0)
    else $error("ring left unaligned after a pass");

  // a dropped insert is only reported on a full store
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == STAT_FULL |-> out_ch.count == CNT_W'(CAPACITY))
    else $error("full status with room left");

  // a completed remove shrinks the store by one
  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE && last_step |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not shrink the count");
endmodule
